FILE: rtl/trc_pkg.sv
`timescale 1ns / 1ps

package trc_pkg;

    // Scan store depth and register reset values
    localparam int unsigned SCAN_DEPTH_DEFAULT = 1024;
    localparam int unsigned CENTER_IDX_W       = 10;
    localparam logic [15:0] THRESHOLD_RESET    = 16'h8000;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [15:0] score;
        logic               last_in_scan;
    } marker_t;

    typedef struct packed {
        logic signed [31:0]             center_x;
        logic signed [31:0]             center_y;
        logic        [15:0]             center_score;
        logic        [CENTER_IDX_W-1:0] center_index;
    } center_t;

    // One stored marker
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [15:0] score;
    } entry_t;

endpackage

FILE: rtl/trc_mem.sv
`timescale 1ns / 1ps

module trc_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  trc_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output trc_pkg::entry_t rd_data
);
    import trc_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/trc_ctrl.sv
`timescale 1ns / 1ps

module trc_ctrl #(
    parameter int unsigned SCAN_DEPTH = 1024,
    parameter int unsigned AW         = $clog2(SCAN_DEPTH),
    parameter int unsigned CW         = $clog2(SCAN_DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  trc_pkg::marker_t marker,
    input  logic [15:0]      threshold,
    output logic             wr_en,
    output logic [AW-1:0]    wr_addr,
    output logic             rd_en,
    output logic [AW-1:0]    rd_addr
);
    import trc_pkg::*;

    logic [CW-1:0] item_index_reg, item_index_next;
    logic [AW-1:0] region_start_reg, region_start_next;
    logic          in_region_reg, in_region_next;

    logic          in_depth;
    logic          above;
    logic          opening;
    logic          closing;
    logic [AW:0]   mid_sum;

    assign in_depth = item_index_reg < CW'(SCAN_DEPTH);
    assign above    = marker.score >= threshold;
    assign opening  = !in_region_reg && above;
    assign closing  = in_region_reg && (!above || marker.last_in_scan);
    assign mid_sum  = {1'b0, item_index_reg[AW-1:0]} + {1'b0, region_start_reg};

    assign wr_en   = accept && in_depth;
    assign wr_addr = item_index_reg[AW-1:0];
    assign rd_en   = accept && in_depth && closing;
    assign rd_addr = mid_sum[AW:1];

    always_comb
    begin
        item_index_next   = item_index_reg;
        region_start_next = region_start_reg;
        in_region_next    = in_region_reg;
        if (accept)
        begin
            if (in_depth)
            begin
                if (opening)
                begin
                    in_region_next    = 1'b1;
                    region_start_next = item_index_reg[AW-1:0];
                end
                else if (closing)
                begin
                    in_region_next = 1'b0;
                end
                item_index_next = item_index_reg + CW'(1);
            end
            // End of scan: drop any open region and restart the index
            if (marker.last_in_scan)
            begin
                item_index_next = '0;
                in_region_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_index_reg   <= '0;
            region_start_reg <= '0;
            in_region_reg    <= 1'b0;
        end
        else
        begin
            item_index_reg   <= item_index_next;
            region_start_reg <= region_start_next;
            in_region_reg    <= in_region_next;
        end
    end

endmodule

FILE: rtl/threshold_run_center_detector.sv
`timescale 1ns / 1ps
// Threshold run center detector.
// Input channel (marker_valid / marker_stall / marker): one marker of a scan per
// transfer, in scan order, with last_in_scan on the final one. Output channel
// (center_valid / center_stall / center): one transfer per closed region, the
// stored marker halfway between the region's first index and the closing index.
// Configuration channel (cfg_valid / cfg_ready / cfg_data): writes the score
// threshold; cfg_ready is always high. Write it only while the block is idle.
// Path: the marker transfer that closes the region reads the middle entry into
// the store's read register, which then moves into the output register.
// Throughput: one marker per cycle while marker_stall is low; each marker needs
// at most one store write and at most one store read, both in the cycle of its transfer.
// Stall: the output register plus the read stage form two slots; marker_stall
// rises only when both are full and center_stall is high.
// Reset: clears the scan index, region flag, valid flags and sets the threshold
// to 0x8000. The marker store is not cleared; only entries written in the
// current scan are ever read.
module threshold_run_center_detector #(
    parameter int unsigned SCAN_DEPTH = trc_pkg::SCAN_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             marker_valid,
    output logic             marker_stall,
    input  trc_pkg::marker_t marker,
    output logic             center_valid,
    input  logic             center_stall,
    output trc_pkg::center_t center,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [15:0]      cfg_data
);
    import trc_pkg::*;

    localparam int unsigned AW = $clog2(SCAN_DEPTH);
    localparam int unsigned CW = $clog2(SCAN_DEPTH + 1);

    logic [15:0]   threshold_reg, threshold_next;

    logic          accept;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        wr_data;
    entry_t        rd_data;

    // Read stage: memory output register is valid
    logic          p1_valid_reg, p1_valid_next;
    logic [AW-1:0] p1_index_reg;
    logic          p1_advance;

    logic          center_valid_reg, center_valid_next;
    center_t       center_reg;
    logic [31:0]   mid_wide;

    // Threshold register
    assign cfg_ready = 1'b1;

    always_comb
    begin
        threshold_next = threshold_reg;
        if (cfg_valid && cfg_ready)
        begin
            threshold_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    // Advance the read stage whenever the output slot is empty or draining
    assign p1_advance   = !center_valid_reg || !center_stall;
    assign marker_stall = p1_valid_reg && !p1_advance;
    assign accept       = marker_valid && !marker_stall;

    assign wr_data.pos_x = marker.pos_x;
    assign wr_data.pos_y = marker.pos_y;
    assign wr_data.score = marker.score;

    trc_ctrl #(
        .SCAN_DEPTH (SCAN_DEPTH),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .marker    (marker),
        .threshold (threshold_reg),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    // The middle index always lies below the write index, so the same-cycle
    // write never hits the entry being read.
    trc_mem #(
        .DEPTH (SCAN_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (rd_en)
        begin
            p1_valid_next = 1'b1;
        end
        else if (p1_advance)
        begin
            p1_valid_next = 1'b0;
        end
        else
        begin
            p1_valid_next = p1_valid_reg;
        end
    end

    // Output slot stays full while stalled, refills from the read stage
    assign center_valid_next = p1_valid_reg || (center_valid_reg && center_stall);
    assign mid_wide          = 32'(p1_index_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg     <= 1'b0;
            center_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg     <= p1_valid_next;
            center_valid_reg <= center_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            p1_index_reg <= rd_addr;
        end
        if (p1_valid_reg && p1_advance)
        begin
            center_reg.center_x     <= rd_data.pos_x;
            center_reg.center_y     <= rd_data.pos_y;
            center_reg.center_score <= rd_data.score;
            center_reg.center_index <= mid_wide[CENTER_IDX_W-1:0];
        end
    end

    assign center_valid = center_valid_reg;
    assign center       = center_reg;

endmodule

FILE: rtl/trc_checker.sv
`timescale 1ns / 1ps

module trc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             marker_valid,
    input logic             marker_stall,
    input trc_pkg::marker_t marker,
    input logic             center_valid,
    input logic             center_stall,
    input trc_pkg::center_t center,
    input logic             cfg_valid,
    input logic             cfg_ready
);
    import trc_pkg::*;

    logic marker_xfer;

    assign marker_xfer = marker_valid && !marker_stall;

    // A stalled center holds
    a_center_hold: assert property (@(posedge clk) disable iff (!rst_n)
        center_valid && center_stall |=> center_valid && $stable(center))
        else $error("center changed while stalled");

    // A stalled marker holds
    a_marker_hold: assert property (@(posedge clk) disable iff (!rst_n)
        marker_valid && marker_stall |=> marker_valid && $stable(marker))
        else $error("marker changed while stalled");

    // Markers back up only when the output slot is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        marker_stall |-> center_valid && center_stall)
        else $error("marker stall without output backpressure");

    // A fresh center follows a marker transfer, by way of the store read and the output register
    a_center_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(center_valid) |-> $past(marker_xfer, 2))
        else $error("center appeared without a closing marker");

    // Configuration writes are never refused
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind threshold_run_center_detector trc_checker u_trc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .marker_valid (marker_valid),
    .marker_stall (marker_stall),
    .marker       (marker),
    .center_valid (center_valid),
    .center_stall (center_stall),
    .center       (center),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);
